// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FPT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define FPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/fpt_pkg.sv =====
// Package: operation codes, widths and controller/datapath interface types
`timescale 1ns / 1ps
`default_nettype none

package fpt_pkg;

  localparam int MAX_FRAMES_DEF = 1024;
  localparam int TIME_W         = 64;
  localparam int ENTRY_W        = 16;
  localparam int FCOUNT_W       = 11;
  localparam int FRAME_W        = 10;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_NEW_SEG   = 3'd1,
    OP_UPDATE    = 3'd2,
    OP_STEP_FWD  = 3'd3,
    OP_STEP_BACK = 3'd4,
    OP_SEEK      = 3'd5,
    OP_PAUSE     = 3'd6
  } op_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic upd_prime;
    logic upd_step;
    logic upd_finish;
    logic seek_idx;
    logic seek_first;
    logic seek_delta;
    logic seek_anchor;
    logic out_load;
  } fpt_cmd_t;

  typedef struct packed {
    logic upd_ok;
    logic seek_empty;
    logic search_done;
  } fpt_status_t;

endpackage

`default_nettype wire

// ===== sv/frame_playhead_tracker.sv =====
// Top level: frame playhead tracker, controller plus datapath
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  command  | cmd_valid / cmd_stall | operation, entry_index, media_time,
//           |                       | media_time_valid, wall_time, frame_count
//  result   | res_valid / res_stall | frame_index, segment_ended, paused_flag,
//           |                       | anchor_time
//
//  One transaction at a time; the result is registered, so the next command is
//  taken while a result still waits. Seek reads the single memory read port twice.
//  Update (when not paused, with entries and a first time set) searches the table,
//  one step per cycle through the registered memory read, at most
//  log2(MAX_FRAMES)+1 steps.
//  Synchronous reset clears the playhead state; the table holds no reset value.
//  A stalled result holds the controller in its result state.
`timescale 1ns / 1ps
`default_nettype none

module frame_playhead_tracker import fpt_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cmd_valid,
  output logic                          cmd_stall,
  input  wire logic [2:0]               operation,
  input  wire logic [ENTRY_W-1:0]       entry_index,
  input  wire logic signed [TIME_W-1:0] media_time,
  input  wire logic                     media_time_valid,
  input  wire logic signed [TIME_W-1:0] wall_time,
  input  wire logic [FCOUNT_W-1:0]      frame_count,
  output logic                          res_valid,
  input  wire logic                     res_stall,
  output logic [FRAME_W-1:0]            frame_index,
  output logic                          segment_ended,
  output logic                          paused_flag,
  output logic signed [TIME_W-1:0]      anchor_time
);

  fpt_cmd_t    cmd;
  fpt_status_t status;

  fpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .operation (operation),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .cmd       (cmd)
  );

  fpt_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .operation        (operation),
    .entry_index      (entry_index),
    .media_time       (media_time),
    .media_time_valid (media_time_valid),
    .wall_time        (wall_time),
    .frame_count      (frame_count),
    .frame_index      (frame_index),
    .segment_ended    (segment_ended),
    .paused_flag      (paused_flag),
    .anchor_time      (anchor_time)
  );

endmodule

`default_nettype wire

// ===== sv/fpt_ctrl.sv =====
// Controller: sequences each transaction and drives the handshakes
`timescale 1ns / 1ps
`default_nettype none

module fpt_ctrl import fpt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire logic [2:0]  operation,
  output logic             res_valid,
  input  wire logic        res_stall,
  input  wire fpt_status_t status,
  output fpt_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_U_PRIME,
    S_U_STEP,
    S_U_FINISH,
    S_K_IDX,
    S_K_FIRST,
    S_K_DELTA,
    S_K_ANCHOR,
    S_RESULT
  } state_t;

  state_t state;

  always_comb begin
    cmd             = '0;
    cmd.capture     = (state == S_IDLE) && cmd_valid;
    cmd.exec        = (state == S_EXEC);
    cmd.upd_prime   = (state == S_U_PRIME);
    cmd.upd_step    = (state == S_U_STEP);
    cmd.upd_finish  = (state == S_U_FINISH);
    cmd.seek_idx    = (state == S_K_IDX);
    cmd.seek_first  = (state == S_K_FIRST);
    cmd.seek_delta  = (state == S_K_DELTA);
    cmd.seek_anchor = (state == S_K_ANCHOR);
    cmd.out_load    = (state == S_RESULT) && (!res_valid || !res_stall);
  end

  assign cmd_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (op_t'(operation))
              OP_UPDATE: state <= status.upd_ok ? S_U_PRIME : S_EXEC;
              OP_SEEK:   state <= status.seek_empty ? S_EXEC : S_K_IDX;
              default:   state <= S_EXEC;
            endcase
          end
        end
        S_EXEC:     state <= S_RESULT;
        S_U_PRIME:  state <= S_U_STEP;
        S_U_STEP: begin
          if (status.search_done) begin
            state <= S_U_FINISH;
          end
        end
        S_U_FINISH: state <= S_RESULT;
        S_K_IDX:    state <= S_K_FIRST;
        S_K_FIRST:  state <= S_K_DELTA;
        S_K_DELTA:  state <= S_K_ANCHOR;
        S_K_ANCHOR: state <= S_RESULT;
        S_RESULT: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/fpt_dp.sv =====
// Datapath: timestamp memory, playhead state, search and seek arithmetic
`timescale 1ns / 1ps
`default_nettype none

module fpt_dp import fpt_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire fpt_cmd_t                   cmd,
  output fpt_status_t                     status,
  input  wire logic [2:0]                 operation,
  input  wire logic [ENTRY_W-1:0]         entry_index,
  input  wire logic signed [TIME_W-1:0]   media_time,
  input  wire logic                       media_time_valid,
  input  wire logic signed [TIME_W-1:0]   wall_time,
  input  wire logic [FCOUNT_W-1:0]        frame_count,
  output logic [FRAME_W-1:0]              frame_index,
  output logic                            segment_ended,
  output logic                            paused_flag,
  output logic signed [TIME_W-1:0]        anchor_time
);

  localparam int IDX_W = $clog2(MAX_FRAMES);
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  logic [TIME_W-1:0]   mem [MAX_FRAMES];
  logic [TIME_W-1:0]   rd_data;
  logic [IDX_W-1:0]    rd_addr;

  op_t                 op_q;
  logic [ENTRY_W-1:0]  index_q;
  logic [TIME_W-1:0]   mtime_q;
  logic                mvalid_q;
  logic [TIME_W-1:0]   wall_q;
  logic [FCOUNT_W-1:0] fcount_q;

  logic [TIME_W-1:0]   diff;
  logic [TIME_W-1:0]   target;
  logic [CNT_W-1:0]    base;
  logic [CNT_W-1:0]    len;

  logic [CNT_W-1:0]    stored_count;
  logic [IDX_W-1:0]    playhead;
  logic [TIME_W-1:0]   first_time;
  logic                first_set;
  logic [TIME_W-1:0]   anchor;
  logic                paused;
  logic                ended;

  logic [CNT_W-1:0]    half;
  logic [CNT_W-1:0]    mid;
  logic                probe_less;
  logic [CNT_W-1:0]    base_next;
  logic [CNT_W-1:0]    len_next;
  logic [CNT_W-1:0]    fcount_sat;
  logic [CNT_W-1:0]    total;
  logic [CNT_W-1:0]    ph_inc;
  logic [IDX_W-1:0]    seek_target;
  logic [TIME_W-1:0]   delta_pos;

  always_comb begin
    half       = len >> 1;
    mid        = base + half;
    probe_less = $signed(rd_data) < $signed(target);
    base_next  = probe_less ? mid + 1'b1 : base;
    len_next   = probe_less ? len - half - 1'b1 : half;

    fcount_sat = (32'(fcount_q) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : CNT_W'(fcount_q);
    total      = (fcount_q != '0) ? fcount_sat : stored_count;
    ph_inc     = CNT_W'(playhead) + 1'b1;

    seek_target = (32'(index_q) >= 32'(stored_count)) ? IDX_W'(stored_count - 1'b1)
                                                      : IDX_W'(index_q);
    delta_pos   = diff[TIME_W-1] ? '0 : diff;

    if (cmd.upd_prime) begin
      rd_addr = IDX_W'(stored_count >> 1);
    end else if (cmd.upd_step) begin
      rd_addr = IDX_W'(base_next + (len_next >> 1));
    end else if (cmd.seek_first) begin
      rd_addr = playhead;
    end else begin
      rd_addr = '0;
    end

    status.upd_ok      = !paused && (stored_count != '0) && first_set;
    status.seek_empty  = (stored_count == '0);
    status.search_done = (len_next == '0);
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (cmd.exec && (op_q == OP_LOAD) && (32'(index_q) < MAX_FRAMES)) begin
      mem[index_q[IDX_W-1:0]] <= mtime_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= op_t'(operation);
      index_q  <= entry_index;
      mtime_q  <= media_time;
      mvalid_q <= media_time_valid;
      wall_q   <= wall_time;
      fcount_q <= frame_count;
      diff     <= wall_time - anchor;
    end
    if (cmd.upd_prime) begin
      target <= first_time + diff;
      base   <= '0;
      len    <= stored_count;
    end
    if (cmd.upd_step) begin
      base <= base_next;
      len  <= len_next;
    end
    if (cmd.seek_delta) begin
      diff <= rd_data - first_time;
    end
    if (cmd.out_load) begin
      frame_index   <= FRAME_W'(32'(playhead));
      segment_ended <= ended;
      paused_flag   <= paused;
      anchor_time   <= anchor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      playhead     <= '0;
      first_time   <= '0;
      first_set    <= 1'b0;
      anchor       <= '0;
      paused       <= 1'b0;
      ended        <= 1'b0;
    end else begin
      if (cmd.capture) begin
        ended <= 1'b0;
      end
      if (cmd.exec) begin
        case (op_q)
          OP_NEW_SEG: begin
            stored_count <= fcount_sat;
            playhead     <= '0;
            first_set    <= mvalid_q;
            first_time   <= mvalid_q ? mtime_q : '0;
            anchor       <= wall_q;
          end
          OP_STEP_FWD: begin
            if (total != '0) begin
              playhead <= (ph_inc >= total) ? IDX_W'(total - 1'b1) : IDX_W'(ph_inc);
            end
          end
          OP_STEP_BACK: begin
            if (playhead != '0) begin
              playhead <= playhead - 1'b1;
            end
          end
          OP_SEEK:  playhead <= '0;
          OP_PAUSE: paused <= !paused;
          default: ;
        endcase
      end
      if (cmd.upd_finish) begin
        if (base == stored_count) begin
          playhead <= IDX_W'(stored_count - 1'b1);
          ended    <= 1'b1;
        end else if ((base != '0) && ($signed(target) < $signed(rd_data))) begin
          playhead <= IDX_W'(base - 1'b1);
        end else begin
          playhead <= IDX_W'(base);
        end
      end
      if (cmd.seek_idx) begin
        playhead <= seek_target;
      end
      if (cmd.seek_first && !first_set) begin
        first_time <= rd_data;
        first_set  <= 1'b1;
      end
      if (cmd.seek_anchor) begin
        anchor <= wall_q - delta_pos;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/fpt_checker.sv =====
// Checker on the tracker ports, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fpt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic cmd_valid,
  input wire logic cmd_stall,
  input wire logic res_valid,
  input wire logic res_stall,
  input wire logic segment_ended,
  input wire logic paused_flag
);

  `FPT_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid)
  `FPT_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd_valid && !cmd_stall, cmd_stall)
  `FPT_ASSERT_NOW(a_ended_not_paused, clk, rst, res_valid && segment_ended, !paused_flag)

endmodule

bind frame_playhead_tracker fpt_checker u_fpt_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd_valid),
  .cmd_stall     (cmd_stall),
  .res_valid     (res_valid),
  .res_stall     (res_stall),
  .segment_ended (segment_ended),
  .paused_flag   (paused_flag)
);

`default_nettype wire
